### rtl/core/pfp_pkg.sv
// Package for the position frame parser.
// Holds the result type, field codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package pfp_pkg;

  localparam int ByteWidth = 8;
  localparam int CountWidth = 7;
  localparam int BitsWidth = 64;
  localparam int RunWidth = 2;
  localparam int CfgIndexWidth = 2;

  localparam logic [ByteWidth-1:0] StartMarkerReset = 8'h55;
  localparam logic [ByteWidth-1:0] EndMarkerReset = 8'hF0;
  localparam logic [CountWidth-1:0] MaxLengthReset = 7'd100;

  localparam logic [CfgIndexWidth-1:0] CfgStartMarker = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgEndMarker = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgMaxLength = 2'd2;

  typedef enum logic [2:0] {
    FIELD_NONE      = 3'd0,
    FIELD_LATITUDE  = 3'd1,
    FIELD_LONGITUDE = 3'd2,
    FIELD_HEIGHT    = 3'd3,
    FIELD_PITCH     = 3'd4,
    FIELD_ROLL      = 3'd5,
    FIELD_HEADING   = 3'd6
  } field_id_t;

  typedef struct packed {
    field_id_t                field_id;
    logic [BitsWidth-1:0]     field_bits;
    logic                     frame_done;
    logic                     overflow;
    logic                     receiving;
  } result_t;

  // Maps a payload byte count to the field that completes at that count.
  function automatic field_id_t field_for_count(input logic [CountWidth:0] count);
    field_id_t id;
    begin
      case (count)
        8'd8:    id = FIELD_LATITUDE;
        8'd16:   id = FIELD_LONGITUDE;
        8'd20:   id = FIELD_HEIGHT;
        8'd24:   id = FIELD_PITCH;
        8'd28:   id = FIELD_ROLL;
        8'd32:   id = FIELD_HEADING;
        default: id = FIELD_NONE;
      endcase
      return id;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/pfp_core.sv
// Parser state, configuration registers and the per-byte update logic.
// Depends on pfp_pkg for the result type, field codes and reset values.
`default_nettype none

module pfp_core #(
  parameter int MARKER_COUNT = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [pfp_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [pfp_pkg::ByteWidth-1:0]       cfg_data,
  input  wire logic                                step,
  input  wire logic [pfp_pkg::ByteWidth-1:0]       rx_byte,
  output pfp_pkg::result_t                         result
);

  localparam logic [pfp_pkg::RunWidth-1:0] RunTarget = pfp_pkg::RunWidth'(MARKER_COUNT);

  logic [pfp_pkg::ByteWidth-1:0]  start_marker;
  logic [pfp_pkg::ByteWidth-1:0]  end_marker;
  logic [pfp_pkg::CountWidth-1:0] max_length;

  logic                           in_payload, in_payload_next;
  logic [pfp_pkg::RunWidth-1:0]   start_run, start_run_next;
  logic [pfp_pkg::RunWidth-1:0]   end_run, end_run_next;
  logic [pfp_pkg::CountWidth-1:0] payload_count, payload_count_next;
  logic [pfp_pkg::BitsWidth-1:0]  recent_bytes, recent_bytes_next;

  logic [pfp_pkg::CountWidth:0]   count_inc;
  pfp_pkg::field_id_t             id;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= pfp_pkg::StartMarkerReset;
      end_marker <= pfp_pkg::EndMarkerReset;
      max_length <= pfp_pkg::MaxLengthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        pfp_pkg::CfgStartMarker: start_marker <= cfg_data;
        pfp_pkg::CfgEndMarker:   end_marker <= cfg_data;
        pfp_pkg::CfgMaxLength:   max_length <= cfg_data[pfp_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_payload_next = in_payload;
    start_run_next = start_run;
    end_run_next = end_run;
    payload_count_next = payload_count;
    recent_bytes_next = recent_bytes;
    count_inc = {1'b0, payload_count} + 8'd1;
    id = pfp_pkg::FIELD_NONE;
    result = '0;

    if (!in_payload) begin
      if (rx_byte == start_marker) begin
        start_run_next = start_run + 2'd1;
        if (start_run_next == RunTarget) begin
          in_payload_next = 1'b1;
          start_run_next = '0;
        end
      end else begin
        start_run_next = '0;
      end
    end else begin
      recent_bytes_next = {rx_byte, recent_bytes[pfp_pkg::BitsWidth-1:pfp_pkg::ByteWidth]};
      id = pfp_pkg::field_for_count(count_inc);
      result.field_id = id;
      if (id == pfp_pkg::FIELD_LATITUDE || id == pfp_pkg::FIELD_LONGITUDE) begin
        result.field_bits = recent_bytes_next;
      end else if (id != pfp_pkg::FIELD_NONE) begin
        result.field_bits = {32'd0, recent_bytes_next[63:32]};
      end
      payload_count_next = count_inc[pfp_pkg::CountWidth-1:0];
      if (count_inc > {1'b0, max_length}) begin
        payload_count_next = '0;
        in_payload_next = 1'b0;
        result.overflow = 1'b1;
      end
      if (rx_byte == end_marker) begin
        end_run_next = end_run + 2'd1;
        if (end_run_next == RunTarget) begin
          end_run_next = '0;
          in_payload_next = 1'b0;
          payload_count_next = '0;
          result.frame_done = 1'b1;
        end
      end else begin
        end_run_next = '0;
      end
    end
    result.receiving = in_payload_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      start_run <= '0;
      end_run <= '0;
      payload_count <= '0;
      recent_bytes <= '0;
    end else if (step) begin
      in_payload <= in_payload_next;
      start_run <= start_run_next;
      end_run <= end_run_next;
      payload_count <= payload_count_next;
      recent_bytes <= recent_bytes_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/position_frame_parser_unit.sv
// A word accepted from the slave side is held in the input register; its result
// is registered in the result register and then offered on the master side.
// Throughput: one word per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset clears the parser state and restores the register defaults
// (start marker 0x55, end marker 0xF0, maximum length 100).
`default_nettype none

module position_frame_parser_unit #(
  parameter int MARKER_COUNT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [63:0] field_bits, [64] overflow, [65] receiving
  output logic [2:0]       m_tuser,   // [2:0] field_id
  output logic             m_tlast    // frame_done
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   advance;
  logic                   out_valid;
  pfp_pkg::result_t       step_result;
  pfp_pkg::result_t       out_result;

  assign advance = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  pfp_core #(
    .MARKER_COUNT(MARKER_COUNT)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (advance),
    .rx_byte  (in_byte),
    .result   (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {6'd0, out_result.receiving, out_result.overflow, out_result.field_bits};
  assign m_tuser = out_result.field_id;
  assign m_tlast = out_result.frame_done;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for position_frame_parser_unit: random frames, noise and register settings.
// Predicts every result word in SystemVerilog and compares it on the master side; needs pfp_pkg.

module tb;

  localparam int MarkerRun = 3;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = pfp_pkg::CfgStartMarker;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  position_frame_parser_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0]  opener_byte = pfp_pkg::StartMarkerReset;
  logic [7:0]  closer_byte = pfp_pkg::EndMarkerReset;
  logic [6:0]  length_limit = pfp_pkg::MaxLengthReset;
  logic        rx_active = 1'b0;
  logic [1:0]  opener_run = 2'd0;
  logic [1:0]  closer_run = 2'd0;
  logic [6:0]  byte_count = 7'd0;
  logic [63:0] byte_window = 64'd0;

  logic [7:0]       rx_byte_q[$];
  pfp_pkg::result_t expected_results[$];
  bit               word_pending = 1'b0;
  bit               calm = 1'b0;
  int               send_gap = 0;
  int               stall_gap = 0;
  int               mismatch_count = 0;

  task automatic parse_byte(input logic [7:0] b);
    pfp_pkg::result_t r;
    logic [7:0]       next_count;
    begin
      r = '0;
      if (!rx_active) begin
        if (b == opener_byte) begin
          opener_run = opener_run + 2'd1;
          if (opener_run == MarkerRun) begin
            rx_active = 1'b1;
            opener_run = 2'd0;
          end
        end else begin
          opener_run = 2'd0;
        end
      end else begin
        next_count = {1'b0, byte_count} + 8'd1;
        byte_window = {b, byte_window[63:8]};
        case (next_count)
          8'd8:    r.field_id = pfp_pkg::FIELD_LATITUDE;
          8'd16:   r.field_id = pfp_pkg::FIELD_LONGITUDE;
          8'd20:   r.field_id = pfp_pkg::FIELD_HEIGHT;
          8'd24:   r.field_id = pfp_pkg::FIELD_PITCH;
          8'd28:   r.field_id = pfp_pkg::FIELD_ROLL;
          8'd32:   r.field_id = pfp_pkg::FIELD_HEADING;
          default: r.field_id = pfp_pkg::FIELD_NONE;
        endcase
        if (r.field_id == pfp_pkg::FIELD_LATITUDE || r.field_id == pfp_pkg::FIELD_LONGITUDE) begin
          r.field_bits = byte_window;
        end else if (r.field_id != pfp_pkg::FIELD_NONE) begin
          r.field_bits = {32'd0, byte_window[63:32]};
        end
        byte_count = next_count[6:0];
        if (next_count > {1'b0, length_limit}) begin
          byte_count = 7'd0;
          rx_active = 1'b0;
          r.overflow = 1'b1;
        end
        if (b == closer_byte) begin
          closer_run = closer_run + 2'd1;
          if (closer_run == MarkerRun) begin
            closer_run = 2'd0;
            rx_active = 1'b0;
            byte_count = 7'd0;
            r.frame_done = 1'b1;
          end
        end else begin
          closer_run = 2'd0;
        end
      end
      r.receiving = rx_active;
      expected_results.push_back(r);
    end
  endtask

  // Sender: one word in flight at a time, held until the slave side takes it.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!word_pending) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (rx_byte_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 3);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= rx_byte_q[0];
        word_pending = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      parse_byte(s_tdata);
      void'(rx_byte_q.pop_front());
      word_pending = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_gap > 0) begin
      stall_gap = stall_gap - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_gap = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    begin
      if (exp !== act) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp, act);
        mismatch_count = mismatch_count + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    pfp_pkg::result_t r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word, expected none actual field_id %0d bits %h",
                 $time, m_tuser, m_tdata[63:0]);
        mismatch_count = mismatch_count + 1;
      end else begin
        r = expected_results.pop_front();
        check_field("field_id", 64'(r.field_id), 64'(m_tuser));
        check_field("field_bits", r.field_bits, m_tdata[63:0]);
        check_field("overflow", 64'(r.overflow), 64'(m_tdata[64]));
        check_field("receiving", 64'(r.receiving), 64'(m_tdata[65]));
        check_field("frame_done", 64'(r.frame_done), 64'(m_tlast));
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= value;
      case (idx)
        pfp_pkg::CfgStartMarker: opener_byte = value;
        pfp_pkg::CfgEndMarker:   closer_byte = value;
        pfp_pkg::CfgMaxLength:   length_limit = value[6:0];
        default:                 ;
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task automatic drain();
    begin
      while (rx_byte_q.size() != 0 || word_pending || expected_results.size() != 0) begin
        @(posedge clk);
      end
      repeat (4) @(posedge clk);
    end
  endtask

  task automatic push_frame(input int payload_len, input bit closed);
    begin
      repeat (MarkerRun) rx_byte_q.push_back(opener_byte);
      repeat (payload_len) begin
        if ($urandom_range(0, 7) == 0) begin
          rx_byte_q.push_back(closer_byte);
        end else begin
          rx_byte_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if (closed) begin
        repeat (MarkerRun) rx_byte_q.push_back(closer_byte);
      end
    end
  endtask

  task automatic random_traffic(input int word_budget);
    int pushed;
    int kind;
    begin
      pushed = 0;
      while (pushed < word_budget) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          push_frame($urandom_range(30, 40), 1'b1);
        end else if (kind == 6) begin
          push_frame($urandom_range(0, 29), 1'b1);
        end else if (kind == 7) begin
          push_frame(int'(length_limit) + $urandom_range(1, 8), 1'b0);
        end else if (kind == 8) begin
          repeat ($urandom_range(1, MarkerRun - 1)) rx_byte_q.push_back(opener_byte);
          rx_byte_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 6)) rx_byte_q.push_back(8'($urandom_range(0, 255)));
        end
        pushed = pushed + rx_byte_q.size();
        while (rx_byte_q.size() > 0) @(posedge clk);
      end
      drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: extremes in hunt mode, broken and complete marker runs.
    rx_byte_q.push_back(8'h00);
    rx_byte_q.push_back(8'hFF);
    rx_byte_q.push_back(pfp_pkg::StartMarkerReset);
    rx_byte_q.push_back(pfp_pkg::StartMarkerReset);
    rx_byte_q.push_back(8'h12);
    repeat (MarkerRun) rx_byte_q.push_back(pfp_pkg::EndMarkerReset);
    repeat (MarkerRun) rx_byte_q.push_back(pfp_pkg::StartMarkerReset);
    rx_byte_q.push_back(8'h00);
    rx_byte_q.push_back(8'hFF);
    rx_byte_q.push_back(pfp_pkg::EndMarkerReset);
    rx_byte_q.push_back(pfp_pkg::EndMarkerReset);
    rx_byte_q.push_back(8'h01);
    repeat (MarkerRun) rx_byte_q.push_back(pfp_pkg::EndMarkerReset);
    drain();
    random_traffic(150);

    write_reg(pfp_pkg::CfgStartMarker, 8'h00);
    write_reg(pfp_pkg::CfgEndMarker, 8'hFF);
    write_reg(pfp_pkg::CfgMaxLength, 8'hFF);
    random_traffic(150);

    write_reg(pfp_pkg::CfgStartMarker, 8'hFF);
    write_reg(pfp_pkg::CfgEndMarker, 8'h00);
    write_reg(pfp_pkg::CfgMaxLength, 8'd32);
    random_traffic(150);

    // Same byte opens and closes; every payload word overflows.
    write_reg(pfp_pkg::CfgStartMarker, 8'hA5);
    write_reg(pfp_pkg::CfgEndMarker, 8'hA5);
    write_reg(pfp_pkg::CfgMaxLength, 8'd0);
    write_reg(CfgUnused, 8'hFF);
    random_traffic(100);

    write_reg(pfp_pkg::CfgStartMarker, 8'($urandom_range(0, 255)));
    write_reg(pfp_pkg::CfgEndMarker, 8'($urandom_range(0, 255)));
    write_reg(pfp_pkg::CfgMaxLength, 8'($urandom_range(32, 126)));
    write_reg(CfgUnused, 8'($urandom_range(0, 255)));
    random_traffic(150);

    write_reg(pfp_pkg::CfgStartMarker, 8'($urandom_range(0, 255)));
    write_reg(pfp_pkg::CfgEndMarker, 8'($urandom_range(0, 255)));
    write_reg(pfp_pkg::CfgMaxLength, 8'd126);
    calm = 1'b1;
    random_traffic(150);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/pfp_pkg.sv
rtl/core/pfp_core.sv
rtl/core/position_frame_parser_unit.sv
tb/tb.sv
